@@ src/pcli_pkg.sv @@
// Shared types and constants for the periodic cam lift interpolator.
`timescale 1ns / 1ps
package pcli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DVD_W      = 66;
	localparam int DVS_W      = 34;
	localparam int DCNT_W     = $clog2(DVD_W + 1);

	// configuration register indexes
	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_MIN_LIFT    = 1'b1;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} act_t;

	typedef struct packed {
		act_t               action;
		logic [IDX_W-1:0]   point_index;
		logic signed [31:0] point_angle;
		logic signed [31:0] point_lift;
		logic signed [31:0] crank_angle;
		logic signed [31:0] angle_step;
		logic [31:0]        time_step;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} head_t;

	typedef struct packed {
		logic signed [31:0] raw_lift;
		logic               valve_open;
		logic signed [31:0] clamped_lift;
		logic signed [31:0] closing_velocity;
		logic               velocity_saturated;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quo;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MM,
		S_WRAP_GO,
		S_WRAP,
		S_SRCH,
		S_RL1,
		S_RL2,
		S_RL3,
		S_MUL,
		S_IGO,
		S_IDIV,
		S_CLAMP,
		S_VGO,
		S_VDIV,
		S_FIN
	} st_t;

endpackage

@@ src/pcli_front.sv @@
// Input side: accepts items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
module pcli_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           action,
	input  logic [pcli_pkg::IDX_W-1:0]     point_index,
	input  logic signed [31:0]             point_angle,
	input  logic signed [31:0]             point_lift,
	input  logic signed [31:0]             crank_angle,
	input  logic signed [31:0]             angle_step,
	input  logic [31:0]                    time_step,
	output pcli_pkg::head_t                head,
	input  logic                           head_pop
);

	pcli_pkg::item_t q_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            take, give;
	pcli_pkg::item_t cls;

	// classify the incoming item
	always_comb begin
		cls.action      = action ? pcli_pkg::ACT_QUERY : pcli_pkg::ACT_LOAD;
		cls.point_index = point_index;
		cls.point_angle = point_angle;
		cls.point_lift  = point_lift;
		cls.crank_angle = crank_angle;
		cls.angle_step  = angle_step;
		cls.time_step   = time_step;
	end

	assign full      = cnt_q == 2'd2;
	assign take      = push && !full;
	assign give      = head_pop && (cnt_q != 2'd0);
	assign head.vld  = cnt_q != 2'd0;
	assign head.item = q_q[rp_q];

	// store entries
	always_ff @(posedge clk) begin
		if (take) begin
			q_q[wp_q] <= cls;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take) wp_q <= ~wp_q;
			if (give) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, give};
		end
	end

endmodule

@@ src/pcli_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcli_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pcli_pkg::div_req_t req,
	output pcli_pkg::div_rsp_t rsp
);

	logic                              busy_q, done_q;
	logic [pcli_pkg::DCNT_W-1:0]       cnt_q;
	logic [pcli_pkg::DVD_W-1:0]        dvd_q, quo_q;
	logic [pcli_pkg::DVS_W-1:0]        dvs_q, rem_q;
	logic [pcli_pkg::DVS_W:0]          trial;
	logic                              ge;

	assign trial = {rem_q, dvd_q[pcli_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	// load operands, then shift and subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? pcli_pkg::DVS_W'(trial - {1'b0, dvs_q})
			            : trial[pcli_pkg::DVS_W-1:0];
			quo_q <= {quo_q[pcli_pkg::DVD_W-2:0], ge};
			dvd_q <= {dvd_q[pcli_pkg::DVD_W-2:0], 1'b0};
		end
	end

	// step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pcli_pkg::DCNT_W'(pcli_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pcli_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

@@ src/pcli_back.sv @@
// Execution side: profile memories, query sequencer and result register.
`timescale 1ns / 1ps
module pcli_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pcli_pkg::head_t             head,
	output logic                        head_pop,
	input  logic [pcli_pkg::CNT_W-1:0]  n_pts,
	input  logic [30:0]                 min_lift,
	output pcli_pkg::res_t              res,
	output logic                        res_vld,
	input  logic                        pop
);

	pcli_pkg::st_t st_q, st_d;

	logic [31:0] ang_mem  [pcli_pkg::MAX_POINTS];
	logic [31:0] lift_mem [pcli_pkg::MAX_POINTS];
	logic [31:0] ang_rd_q, lift_rd_q;
	logic [pcli_pkg::IDX_W-1:0] lift_ra;
	logic        we;

	logic [pcli_pkg::CNT_W-1:0] cnt_q;
	logic        pass_q, below_q, lo_f_q, hi_f_q;
	logic signed [31:0] theta_q, step_q, amin_q, amax_q, alo_q, ahi_q;
	logic signed [31:0] ylo_q, yhi_q, y_q, raw_q, cur_q, prev_q;
	logic [31:0] dt_q;
	logic signed [33:0] x_q;
	logic [pcli_pkg::IDX_W-1:0] lo_q, hi_q;
	logic [pcli_pkg::DVD_W-1:0] acc_q;
	logic [5:0]  mcnt_q;
	pcli_pkg::res_t res_q;
	logic        res_vld_q;

	pcli_pkg::div_req_t dreq;
	pcli_pkg::div_rsp_t drsp;

	logic signed [33:0] xin, amin_x, amax_x, a_x, u, y_i;
	logic [33:0]        span, dwrap, w;
	logic signed [32:0] dy, diff;
	logic [32:0]        v, mag, q33;
	logic               go_wrap, interp, lt_min;
	logic signed [31:0] y_clamp, minl;
	logic [31:0]        dt0;

	pcli_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// profile memories, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			ang_mem[head.item.point_index]  <= head.item.point_angle;
			lift_mem[head.item.point_index] <= head.item.point_lift;
		end
		ang_rd_q  <= ang_mem[cnt_q[pcli_pkg::IDX_W-1:0]];
		lift_rd_q <= lift_mem[lift_ra];
	end

	// datapath helpers
	always_comb begin
		xin     = pass_q ? (34'(theta_q) - 34'(step_q)) : 34'(theta_q);
		amin_x  = 34'(amin_q);
		amax_x  = 34'(amax_q);
		span    = 34'(amax_x - amin_x);
		go_wrap = (span != '0) && ((xin < amin_x) || (xin > amax_x));
		dwrap   = (xin < amin_x) ? 34'(amin_x - xin) : 34'(xin - amax_x);
		a_x     = 34'($signed(ang_rd_q));
		dy      = 33'(yhi_q) - 33'(ylo_q);
		v       = dy[32] ? 33'(-dy) : 33'(dy);
		u       = x_q - 34'(alo_q);
		w       = 34'(ahi_q) - 34'(alo_q);
		interp  = lo_f_q && hi_f_q && (lo_q != hi_q);
		q33     = drsp.quo[32:0];
		y_i     = dy[32] ? (34'(ylo_q) - 34'(q33)) : (34'(ylo_q) + 34'(q33));
		minl    = $signed({1'b0, min_lift});
		lt_min  = y_q < minl;
		y_clamp = lt_min ? minl : y_q;
		diff    = 33'(prev_q) - 33'(cur_q);
		mag     = diff[32] ? 33'(-diff) : 33'(diff);
		dt0     = (dt_q == '0) ? 32'd1 : dt_q;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pcli_pkg::S_IDLE: begin
				if (head.vld) begin
					if (head.item.action == pcli_pkg::ACT_QUERY) st_d = pcli_pkg::S_MM;
				end
			end
			pcli_pkg::S_MM:      if (cnt_q == n_pts) st_d = pcli_pkg::S_WRAP_GO;
			pcli_pkg::S_WRAP_GO: st_d = go_wrap ? pcli_pkg::S_WRAP : pcli_pkg::S_SRCH;
			pcli_pkg::S_WRAP:    if (drsp.done) st_d = pcli_pkg::S_SRCH;
			pcli_pkg::S_SRCH:    if (cnt_q == n_pts) st_d = pcli_pkg::S_RL1;
			pcli_pkg::S_RL1:     st_d = pcli_pkg::S_RL2;
			pcli_pkg::S_RL2:     st_d = pcli_pkg::S_RL3;
			pcli_pkg::S_RL3:     st_d = interp ? pcli_pkg::S_MUL : pcli_pkg::S_CLAMP;
			pcli_pkg::S_MUL:     if (mcnt_q == 6'd0) st_d = pcli_pkg::S_IGO;
			pcli_pkg::S_IGO:     st_d = pcli_pkg::S_IDIV;
			pcli_pkg::S_IDIV:    if (drsp.done) st_d = pcli_pkg::S_CLAMP;
			pcli_pkg::S_CLAMP:   st_d = pass_q ? pcli_pkg::S_VGO : pcli_pkg::S_WRAP_GO;
			pcli_pkg::S_VGO:     st_d = pcli_pkg::S_VDIV;
			pcli_pkg::S_VDIV:    if (drsp.done) st_d = pcli_pkg::S_FIN;
			pcli_pkg::S_FIN:     if (!res_vld_q) st_d = pcli_pkg::S_IDLE;
			default:             st_d = pcli_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		head_pop      = 1'b0;
		we            = 1'b0;
		lift_ra       = hi_q;
		dreq.start    = 1'b0;
		dreq.dividend = 66'(dwrap);
		dreq.divisor  = span;
		unique case (st_q)
			pcli_pkg::S_IDLE: begin
				if (head.vld) begin
					if (head.item.action == pcli_pkg::ACT_QUERY) begin
						head_pop = 1'b1;
					end else begin
						head_pop = !res_vld_q;
						we       = !res_vld_q;
					end
				end
			end
			pcli_pkg::S_WRAP_GO: dreq.start = go_wrap;
			pcli_pkg::S_RL1: lift_ra = lo_f_q ? lo_q : (hi_f_q ? hi_q : '0);
			pcli_pkg::S_IGO: begin
				dreq.start    = 1'b1;
				dreq.dividend = acc_q;
				dreq.divisor  = w;
			end
			pcli_pkg::S_VGO: begin
				dreq.start    = 1'b1;
				dreq.dividend = 66'(mag);
				dreq.divisor  = 34'(dt0);
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pcli_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			pcli_pkg::S_IDLE: begin
				cnt_q   <= '0;
				pass_q  <= 1'b0;
				theta_q <= head.item.crank_angle;
				step_q  <= head.item.angle_step;
				dt_q    <= head.item.time_step;
			end
			pcli_pkg::S_MM: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcli_pkg::CNT_W'(1)) begin
					amin_q <= $signed(ang_rd_q);
					amax_q <= $signed(ang_rd_q);
				end else if (cnt_q != '0) begin
					if ($signed(ang_rd_q) < amin_q) amin_q <= $signed(ang_rd_q);
					if ($signed(ang_rd_q) > amax_q) amax_q <= $signed(ang_rd_q);
				end
			end
			pcli_pkg::S_WRAP_GO: begin
				cnt_q   <= '0;
				lo_f_q  <= 1'b0;
				hi_f_q  <= 1'b0;
				x_q     <= xin;
				below_q <= xin < amin_x;
			end
			pcli_pkg::S_WRAP: begin
				// land on the near end when the remainder is zero, else one remainder in from the far end
				if (drsp.done) begin
					if (drsp.rem == '0) x_q <= below_q ? amin_x : amax_x;
					else x_q <= below_q ? (amax_x - 34'(drsp.rem))
					                    : (amin_x + 34'(drsp.rem));
				end
			end
			pcli_pkg::S_SRCH: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q != '0) begin
					if ((a_x <= x_q) && (!lo_f_q || ($signed(ang_rd_q) > alo_q))) begin
						lo_f_q <= 1'b1;
						lo_q   <= pcli_pkg::IDX_W'(cnt_q - 1'b1);
						alo_q  <= $signed(ang_rd_q);
					end
					if ((a_x >= x_q) && (!hi_f_q || ($signed(ang_rd_q) < ahi_q))) begin
						hi_f_q <= 1'b1;
						hi_q   <= pcli_pkg::IDX_W'(cnt_q - 1'b1);
						ahi_q  <= $signed(ang_rd_q);
					end
				end
			end
			pcli_pkg::S_RL2: ylo_q <= $signed(lift_rd_q);
			pcli_pkg::S_RL3: begin
				yhi_q  <= $signed(lift_rd_q);
				y_q    <= ylo_q;
				acc_q  <= '0;
				mcnt_q <= 6'd33;
			end
			pcli_pkg::S_MUL: begin
				// shift-add one multiplier bit per cycle
				acc_q  <= {acc_q[pcli_pkg::DVD_W-2:0], 1'b0} + (u[mcnt_q] ? 66'(v) : '0);
				mcnt_q <= mcnt_q - 1'b1;
			end
			pcli_pkg::S_IDIV: if (drsp.done) y_q <= 32'(y_i);
			pcli_pkg::S_CLAMP: begin
				if (!pass_q) begin
					raw_q  <= y_q;
					cur_q  <= y_clamp;
					pass_q <= 1'b1;
				end else begin
					prev_q <= y_clamp;
				end
			end
			default: ;
		endcase
	end

	// result register, filled only once the previous result has been taken
	always_ff @(posedge clk) begin
		if (st_q == pcli_pkg::S_IDLE && we) begin
			res_q <= '0;
		end else if (st_q == pcli_pkg::S_FIN && !res_vld_q) begin
			res_q.raw_lift     <= raw_q;
			res_q.valve_open   <= raw_q >= minl;
			res_q.clamped_lift <= cur_q;
			if (diff[32]) begin
				res_q.velocity_saturated <= q33 > 33'h0_8000_0000;
				res_q.closing_velocity   <= (q33 > 33'h0_8000_0000) ? 32'sh8000_0000
				                            : 32'(-q33);
			end else begin
				res_q.velocity_saturated <= q33 > 33'h0_7FFF_FFFF;
				res_q.closing_velocity   <= (q33 > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
				                            : 32'(q33);
			end
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if ((st_q == pcli_pkg::S_IDLE && we) ||
		             (st_q == pcli_pkg::S_FIN && !res_vld_q)) begin
			res_vld_q <= 1'b1;
		end else if (pop) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res     = res_q;
	assign res_vld = res_vld_q;

`ifndef SYNTH
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !pop) |=> res_vld_q)
		else $error("result dropped before pop");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy)
		else $error("divider started while busy");
	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pcli_pkg::S_MUL) |-> (mcnt_q < 6'd34))
		else $error("multiplier step out of range");
	a_no_wdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pcli_pkg::S_IGO) |-> (w != '0))
		else $error("interpolation width zero");
`endif

endmodule

@@ src/periodic_cam_lift_interpolator.sv @@
// Top level: configuration registers, input queue and query engine.
`timescale 1ns / 1ps
// A load item writes one profile point; its result has all fields zero. A query runs on one
// item at a time: one pass over the angle memory for the span, then for each of the two angles
// a search pass, a 34-step serial multiply and up to two runs of the shared 66-step divider,
// plus one final divide for the velocity. That divider and the single read port of each
// profile memory set the query's run time. A two-entry input queue keeps accepting items
// while a result waits to be popped, until the queue is full.
module periodic_cam_lift_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic [5:0]         point_index,
	input  logic signed [31:0] point_angle,
	input  logic signed [31:0] point_lift,
	input  logic signed [31:0] crank_angle,
	input  logic signed [31:0] angle_step,
	input  logic [31:0]        time_step,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] raw_lift,
	output logic               valve_open,
	output logic signed [31:0] clamped_lift,
	output logic signed [31:0] closing_velocity,
	output logic               velocity_saturated,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [30:0]        wr_data
);

	logic [6:0]                 pc_q;
	logic [30:0]                ml_q;
	logic [pcli_pkg::CNT_W-1:0] n_pts;
	pcli_pkg::head_t            head;
	logic                       head_pop, res_vld;
	pcli_pkg::res_t             res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 7'd2;
			ml_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				pcli_pkg::REG_POINT_COUNT: pc_q <= wr_data[6:0];
				pcli_pkg::REG_MIN_LIFT:    ml_q <= wr_data;
				default: ;
			endcase
		end
	end

	// clamp the point count to the table
	always_comb begin
		if (pc_q < 7'd2) n_pts = pcli_pkg::CNT_W'(2);
		else if (pc_q > 7'(pcli_pkg::MAX_POINTS)) n_pts = pcli_pkg::CNT_W'(pcli_pkg::MAX_POINTS);
		else n_pts = pcli_pkg::CNT_W'(pc_q);
	end

	pcli_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.point_index(point_index), .point_angle(point_angle), .point_lift(point_lift),
		.crank_angle(crank_angle), .angle_step(angle_step), .time_step(time_step),
		.head(head), .head_pop(head_pop)
	);

	pcli_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_pop(head_pop), .n_pts(n_pts),
		.min_lift(ml_q), .res(res), .res_vld(res_vld), .pop(pop)
	);

	assign empty              = !res_vld;
	assign raw_lift           = res.raw_lift;
	assign valve_open         = res.valve_open;
	assign clamped_lift       = res.clamped_lift;
	assign closing_velocity   = res.closing_velocity;
	assign velocity_saturated = res.velocity_saturated;

endmodule
